// ===== design/mips_subset_single_cycle_core_defines.svh =====
// Assertion macros shared by the checker of the single-cycle core.
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_DEFINES_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSSC_ASSERT_IMPL(lbl, clkx, rstx, ante, cons, msg) \
  lbl: assert property (@(posedge clkx) disable iff (!(rstx)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSSC_ASSERT_NEXT(lbl, clkx, rstx, ante, cons, msg) \
  lbl: assert property (@(posedge clkx) disable iff (!(rstx)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mssc_pkg.sv =====
// Package of types, opcodes and helpers for the single-cycle core.
`timescale 1ns / 1ps
package mssc_pkg;

  localparam int DATA_WORDS = 4096;
  localparam int DATA_AW    = $clog2(DATA_WORDS);

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2b;
  localparam logic [5:0] OP_LL    = 6'h30;
  localparam logic [5:0] OP_SC    = 6'h38;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  localparam logic [1:0] CLS_R   = 2'd0;
  localparam logic [1:0] CLS_I   = 2'd1;
  localparam logic [1:0] CLS_J   = 2'd2;
  localparam logic [1:0] CLS_UNK = 2'd3;

  typedef enum logic [1:0] {
    LD_WORD,
    LD_BYTE,
    LD_HALF
  } load_kind_t;

  typedef struct packed {
    logic [31:0]        npc;
    logic               wr;
    logic [4:0]         dst;
    logic [31:0]        val;
    logic               mw;
    logic [DATA_AW-1:0] maddr;
    logic [11:0]        midx;
    logic [31:0]        mval;
    logic               br;
    logic [1:0]         cls;
    logic               halt;
    logic               ld;
    load_kind_t         ld_kind;
  } exec_res_t;

  // Register contents after reset, for entries not yet written.
  function automatic logic [31:0] rf_reset_val(input logic [4:0] idx);
    logic [31:0] v;
    v = 32'h0;
    if (idx == 5'd31) v = 32'hFFFF_FFFF;
    if (idx == 5'd29) v = 32'h0080_0000;
    return v;
  endfunction

endpackage

// ===== design/mssc_if.sv =====
// Valid/ready channel interfaces for instruction requests and results.
`timescale 1ns / 1ps
interface mssc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface mssc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_write_en;
  logic [4:0]  reg_write_index;
  logic [31:0] reg_write_value;
  logic        mem_write_en;
  logic [11:0] mem_word_index;
  logic [31:0] mem_write_value;
  logic        branch_taken;
  logic [1:0]  instr_class;
  logic        halted;
  modport source (output valid, output next_pc, output reg_write_en, output reg_write_index,
                  output reg_write_value, output mem_write_en, output mem_word_index,
                  output mem_write_value, output branch_taken, output instr_class,
                  output halted, input ready);
  modport sink   (input valid, input next_pc, input reg_write_en, input reg_write_index,
                  input reg_write_value, input mem_write_en, input mem_word_index,
                  input mem_write_value, input branch_taken, input instr_class,
                  input halted, output ready);
endinterface

// ===== design/mssc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mssc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== design/mssc_exec.sv =====
// Decode and execute logic for one instruction.
`timescale 1ns / 1ps
module mssc_exec import mssc_pkg::*; (
  input  logic [31:0] instr,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] pc,
  output exec_res_t   res
);
  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [31:0] zimm, simm, pc4, addr;
  logic [29:0] widx;
  logic        wr;
  logic [4:0]  dst;
  logic [31:0] val;

  always_comb begin
    op   = instr[31:26];
    rt   = instr[20:16];
    rd   = instr[15:11];
    sh   = instr[10:6];
    fn   = instr[5:0];
    zimm = {16'h0, instr[15:0]};
    simm = {{16{instr[15]}}, instr[15:0]};
    pc4  = pc + 32'd4;
    addr = a + simm;
    widx = addr[31:2] & 30'(DATA_WORDS - 1);

    res         = '0;
    res.npc     = pc4;
    res.cls     = CLS_I;
    res.ld_kind = LD_WORD;
    wr  = 1'b0;
    dst = 5'd0;
    val = 32'h0;

    case (op)
      OP_RTYPE: begin
        res.cls = CLS_R;
        dst = rd;
        wr  = 1'b1;
        case (fn)
          FN_ADD, FN_ADDU: val = a + b;
          FN_SUB, FN_SUBU: val = a - b;
          FN_AND:  val = a & b;
          FN_OR:   val = a | b;
          FN_NOR:  val = ~(a | b);
          FN_SLT:  val = {31'h0, $signed(a) < $signed(b)};
          FN_SLTU: val = {31'h0, a < b};
          FN_SLL:  val = b << sh;
          FN_SRL:  val = b >> sh;
          FN_JR: begin
            res.npc = a;
            wr = 1'b0;
          end
          default: wr = 1'b0;
        endcase
      end
      OP_ADDI, OP_ADDIU: begin dst = rt; wr = 1'b1; val = a + simm; end
      OP_ANDI:  begin dst = rt; wr = 1'b1; val = a & zimm; end
      OP_ORI:   begin dst = rt; wr = 1'b1; val = a | zimm; end
      OP_SLTI:  begin dst = rt; wr = 1'b1; val = {31'h0, $signed(a) < $signed(simm)}; end
      OP_SLTIU: begin dst = rt; wr = 1'b1; val = {31'h0, a < simm}; end
      OP_LUI:   begin dst = rt; wr = 1'b1; val = {instr[15:0], 16'h0}; end
      OP_BEQ, OP_BNE: begin
        res.br = (op == OP_BEQ) ? (a == b) : (a != b);
        if (res.br) res.npc = pc4 + {simm[29:0], 2'b00};
      end
      OP_LW, OP_LL, OP_LBU, OP_LHU: begin
        res.maddr = widx[DATA_AW-1:0];
        res.midx  = widx[11:0];
        res.ld    = 1'b1;
        if (op == OP_LBU) res.ld_kind = LD_BYTE;
        if (op == OP_LHU) res.ld_kind = LD_HALF;
        dst = rt;
        wr  = 1'b1;
      end
      OP_SW, OP_SB, OP_SH: begin
        res.maddr = widx[DATA_AW-1:0];
        res.midx  = widx[11:0];
        res.mw    = 1'b1;
        if (op == OP_SB) res.mval = {24'h0, b[7:0]};
        else if (op == OP_SH) res.mval = {16'h0, b[15:0]};
        else res.mval = b;
      end
      OP_SC: ;
      OP_J, OP_JAL: begin
        res.cls = CLS_J;
        res.npc = {pc4[31:28], instr[25:0], 2'b00};
        if (op == OP_JAL) begin
          dst = 5'd31;
          wr  = 1'b1;
          val = pc + 32'd8;
        end
      end
      default: res.cls = CLS_UNK;
    endcase

    // A write to register zero is dropped and reported as no write at all.
    if (wr && (dst != 5'd0)) begin
      res.wr  = 1'b1;
      res.dst = dst;
      res.val = val;
    end else begin
      res.ld = 1'b0;
    end
    res.halt = (res.npc == 32'hFFFF_FFFF);
  end
endmodule

// ===== design/mips_subset_single_cycle_core.sv =====
// Requests pass the instruction register, then the result register; one
// instruction per cycle unless out_ch.ready stalls the output. Register and
// store reads go through registered RAM ports, with forwarding from the
// result stage into execute. Reset: PC and pipeline clear; the data store
// is swept to zero over all DATA_WORDS words; no request is taken meanwhile.
// Register file reset values come from per-entry valid bits.
`timescale 1ns / 1ps
module mips_subset_single_cycle_core import mssc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mssc_in_if.sink     in_ch,
  mssc_out_if.source  out_ch
);
  logic               clr_r, clr_nxt;
  logic [DATA_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic               s1_v_r, s1_v_nxt;
  logic [31:0]        instr_r;
  logic [31:0]        pc_r;
  logic               s2_v_r, s2_fresh_r;
  exec_res_t          s2_r;
  logic [31:0]        rfv_r;
  logic               ok_a_r, ok_b_r, fa_v_r, fb_v_r;
  logic [31:0]        fa_r, fb_r;

  logic               adv, accept, s1_go;
  logic [4:0]         in_rs, in_rt, s1_rs, s1_rt;
  logic [31:0]        ram_a, ram_b, a_eff, b_eff, dm_rdata, ld_val, s2_val;
  logic               wen;
  logic [4:0]         waddr;
  logic [31:0]        wdata;
  exec_res_t          ex;
  logic               dm_we;
  logic [DATA_AW-1:0] dm_waddr;
  logic [31:0]        dm_wdata;

  assign adv    = !s2_v_r || out_ch.ready;
  assign in_ch.ready = !clr_r && (!s1_v_r || adv);
  assign accept = in_ch.valid && in_ch.ready;
  assign s1_go  = s1_v_r && adv;
  assign in_rs  = in_ch.instr_word[25:21];
  assign in_rt  = in_ch.instr_word[20:16];
  assign s1_rs  = instr_r[25:21];
  assign s1_rt  = instr_r[20:16];

  always_comb begin
    case (s2_r.ld_kind)
      LD_BYTE: ld_val = {24'h0, dm_rdata[7:0]};
      LD_HALF: ld_val = {16'h0, dm_rdata[15:0]};
      default: ld_val = dm_rdata;
    endcase
    s2_val = s2_r.ld ? ld_val : s2_r.val;
  end

  // The result stage writes the register file once, in its first cycle.
  assign wen   = s2_v_r && s2_fresh_r && s2_r.wr;
  assign waddr = s2_r.dst;
  assign wdata = s2_val;

  always_comb begin
    if (wen && waddr == s1_rs) a_eff = wdata;
    else if (fa_v_r) a_eff = fa_r;
    else if (ok_a_r) a_eff = ram_a;
    else a_eff = rf_reset_val(s1_rs);
    if (wen && waddr == s1_rt) b_eff = wdata;
    else if (fb_v_r) b_eff = fb_r;
    else if (ok_b_r) b_eff = ram_b;
    else b_eff = rf_reset_val(s1_rt);
  end

  mssc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(wen), .waddr(waddr), .wdata(wdata),
    .re(accept), .raddr(in_rs), .rdata(ram_a)
  );
  mssc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(wen), .waddr(waddr), .wdata(wdata),
    .re(accept), .raddr(in_rt), .rdata(ram_b)
  );

  mssc_exec u_exec (.instr(instr_r), .a(a_eff), .b(b_eff), .pc(pc_r), .res(ex));

  assign dm_we    = clr_r || (s1_go && ex.mw);
  assign dm_waddr = clr_r ? clr_cnt_r : ex.maddr;
  assign dm_wdata = clr_r ? 32'h0 : ex.mval;

  mssc_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dstore (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .re(s1_go), .raddr(ex.maddr), .rdata(dm_rdata)
  );

  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == DATA_AW'(DATA_WORDS - 1)) clr_nxt = 1'b0;
    end
    s1_v_nxt = accept ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_cnt_r  <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s2_fresh_r <= 1'b0;
      pc_r       <= 32'h0;
      rfv_r      <= 32'h0;
      fa_v_r     <= 1'b0;
      fb_v_r     <= 1'b0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      s1_v_r    <= s1_v_nxt;
      if (wen) rfv_r[waddr] <= 1'b1;
      if (adv) begin
        s2_v_r     <= s1_v_r;
        s2_fresh_r <= s1_v_r;
      end else begin
        s2_fresh_r <= 1'b0;
      end
      if (s1_go) pc_r <= ex.npc;
      // Track register writes that land after the RAM read was taken.
      if (accept) begin
        fa_v_r <= wen && waddr == in_rs;
        fb_v_r <= wen && waddr == in_rt;
      end else if (s1_v_r) begin
        if (wen && waddr == s1_rs) fa_v_r <= 1'b1;
        if (wen && waddr == s1_rt) fb_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      instr_r <= in_ch.instr_word;
      ok_a_r  <= rfv_r[in_rs];
      ok_b_r  <= rfv_r[in_rt];
      fa_r    <= wdata;
      fb_r    <= wdata;
    end else if (s1_v_r) begin
      if (wen && waddr == s1_rs) fa_r <= wdata;
      if (wen && waddr == s1_rt) fb_r <= wdata;
    end
    if (s1_go) s2_r <= ex;
  end

  assign out_ch.valid           = s2_v_r;
  assign out_ch.next_pc         = s2_r.npc;
  assign out_ch.reg_write_en    = s2_r.wr;
  assign out_ch.reg_write_index = s2_r.dst;
  assign out_ch.reg_write_value = s2_val;
  assign out_ch.mem_write_en    = s2_r.mw;
  assign out_ch.mem_word_index  = s2_r.midx;
  assign out_ch.mem_write_value = s2_r.mval;
  assign out_ch.branch_taken    = s2_r.br;
  assign out_ch.instr_class     = s2_r.cls;
  assign out_ch.halted          = s2_r.halt;
endmodule

// ===== design/mssc_checker.sv =====
// Port-level checker for the single-cycle core, bound to the top level.
`timescale 1ns / 1ps
`include "mips_subset_single_cycle_core_defines.svh"
module mssc_checker import mssc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_next_pc,
  input logic        out_reg_write_en,
  input logic [4:0]  out_reg_write_index,
  input logic [31:0] out_reg_write_value,
  input logic        out_mem_write_en,
  input logic [31:0] out_mem_write_value,
  input logic        out_branch_taken,
  input logic [1:0]  out_instr_class
);
  `MSSC_ASSERT_IMPL(a_no_write_zero, clk, rst_n, out_valid && !out_reg_write_en, out_reg_write_index == 5'd0 && out_reg_write_value == 32'h0, "register write fields set without a write")
  `MSSC_ASSERT_IMPL(a_no_store_zero, clk, rst_n, out_valid && !out_mem_write_en, out_mem_write_value == 32'h0, "store data set without a store")
  `MSSC_ASSERT_IMPL(a_branch_itype, clk, rst_n, out_valid && out_branch_taken, out_instr_class == CLS_I && !out_reg_write_en && !out_mem_write_en, "taken branch with other effects")
  `MSSC_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_next_pc), "stalled result changed")
endmodule

bind mips_subset_single_cycle_core mssc_checker u_mssc_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_next_pc(out_ch.next_pc),
  .out_reg_write_en(out_ch.reg_write_en),
  .out_reg_write_index(out_ch.reg_write_index),
  .out_reg_write_value(out_ch.reg_write_value),
  .out_mem_write_en(out_ch.mem_write_en),
  .out_mem_write_value(out_ch.mem_write_value),
  .out_branch_taken(out_ch.branch_taken),
  .out_instr_class(out_ch.instr_class)
);
